// ----- src/b64c_pkg.sv -----
// Shared types, constants and symbol mapping functions for the Base64 stream codec.
`default_nettype none

package b64c_pkg;

	// Field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SYM_W = 6;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned MAX_RES = 4;
	localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
	localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE = 8'd2;

	// Configuration reset values
	localparam logic DIRECTION_RST = 1'b0;
	localparam logic ALPHABET_RST = 1'b0;
	localparam logic PAD_ENABLE_RST = 1'b1;

	// Direction and alphabet codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;
	localparam logic ALPH_STANDARD = 1'b0;
	localparam logic ALPH_URL = 1'b1;

	// Characters
	localparam logic [BYTE_W-1:0] CHAR_PAD = 8'h3D;	// '='
	localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [BYTE_W-1:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2B;
	localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;

	// Symbol values
	localparam logic [SYM_W-1:0] SYM_LOWER_BASE = 6'd26;
	localparam logic [SYM_W-1:0] SYM_DIGIT_BASE = 6'd52;
	localparam logic [SYM_W-1:0] SYM_62 = 6'd62;
	localparam logic [SYM_W-1:0] SYM_63 = 6'd63;

	// One result beat
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_valid;
		logic              out_last;
		logic              decode_error;
	} res_beat_t;

	// Decoded symbol with an invalid flag
	typedef struct packed {
		logic             bad;
		logic [SYM_W-1:0] sym;
	} sym_look_t;

	// Map a six-bit symbol to its character
	function automatic logic [BYTE_W-1:0] sym_to_char(input logic [SYM_W-1:0] v,
		input logic alph);
		logic [BYTE_W-1:0] c;
		if (v < SYM_LOWER_BASE) begin
			c = CHAR_UPPER_A + BYTE_W'(v);
		end else if (v < SYM_DIGIT_BASE) begin
			c = CHAR_LOWER_A + BYTE_W'(v - SYM_LOWER_BASE);
		end else if (v < SYM_62) begin
			c = CHAR_DIGIT_0 + BYTE_W'(v - SYM_DIGIT_BASE);
		end else if (v == SYM_62) begin
			c = (alph == ALPH_URL) ? CHAR_MINUS : CHAR_PLUS;
		end else begin
			c = (alph == ALPH_URL) ? CHAR_UNDERSCORE : CHAR_SLASH;
		end
		return c;
	endfunction

	// Map a character back to its symbol; flag anything outside the alphabet (URL also takes + and /)
	function automatic sym_look_t char_to_sym(input logic [BYTE_W-1:0] c, input logic alph);
		sym_look_t r;
		r.bad = 1'b0;
		r.sym = '0;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r.sym = SYM_W'(c - CHAR_UPPER_A);
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			r.sym = SYM_W'(c - CHAR_LOWER_A) + SYM_LOWER_BASE;
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			r.sym = SYM_W'(c - CHAR_DIGIT_0) + SYM_DIGIT_BASE;
		end else if (c == CHAR_PLUS) begin
			r.sym = SYM_62;
		end else if (c == CHAR_SLASH) begin
			r.sym = SYM_63;
		end else if (alph == ALPH_URL && c == CHAR_MINUS) begin
			r.sym = SYM_62;
		end else if (alph == ALPH_URL && c == CHAR_UNDERSCORE) begin
			r.sym = SYM_63;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/b64c_if.sv -----
// Valid/ready channel interfaces for input items, result beats and register writes.
`default_nettype none

interface b64c_item_if
	import b64c_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface b64c_res_if
	import b64c_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_valid;
	logic              out_last;
	logic              decode_error;

	modport source (output valid, out_byte, out_valid, out_last, decode_error, input ready);
	modport sink (input valid, out_byte, out_valid, out_last, decode_error, output ready);
endinterface

interface b64c_cfg_if
	import b64c_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/base64_stream_codec_top.sv -----
// Base64 stream codec top level: group state, single-pass mapping and result buffer.
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+-----------
//  item     | in  | in_byte[7:0], in_last                          | valid/ready
//  result   | out | out_byte[7:0], out_valid, out_last, decode_error| valid/ready
//  cfg      | in  | index[7:0], data[7:0] (bit 0 used)             | valid/ready
//
// An accepted item is mapped in the same cycle into zero to four result beats, held in
// a four-entry buffer that sends one beat per cycle while result is ready. The input is
// held while beats remain; the next item is taken in the cycle the last beat leaves.
// Reset clears the buffer, the group state and the registers (pad_enable resets to 1).
// A stalled result holds its beat; the cfg channel is always ready.
`default_nettype none

module base64_stream_codec_top
	import b64c_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	b64c_item_if.sink   item,
	b64c_res_if.source  result,
	b64c_cfg_if.sink    cfg
);

	// Configuration and group state
	logic              direction_q;
	logic              alphabet_q;
	logic              pad_enable_q;
	logic [1:0]        phase_q;
	logic [SYM_W-1:0]  carry_q;
	logic              halted_q;
	logic              third_missing_q;

	// Result buffer
	res_beat_t              res_q [MAX_RES];
	logic [RES_CNT_W-1:0]   cnt_q;

	// Next-state and result list
	res_beat_t              beat [MAX_RES];
	logic [RES_CNT_W-1:0]   n_beats;
	logic [1:0]             phase_d;
	logic [SYM_W-1:0]       carry_d;
	logic                   halted_d;
	logic                   third_missing_d;
	sym_look_t              look;

	logic item_acc;
	logic res_pop;
	logic cfg_acc;

	assign res_pop = result.valid && result.ready;
	assign item_acc = item.valid && item.ready;
	assign cfg_acc = cfg.valid && cfg.ready;

	// Take a new item once the buffer empties in this cycle
	assign item.ready = (cnt_q == RES_CNT_W'(0)) ||
		(cnt_q == RES_CNT_W'(1) && result.ready);
	assign cfg.ready = 1'b1;

	assign result.valid = (cnt_q != RES_CNT_W'(0));
	assign result.out_byte = res_q[0].out_byte;
	assign result.out_valid = res_q[0].out_valid;
	assign result.out_last = res_q[0].out_last;
	assign result.decode_error = res_q[0].decode_error;

	assign look = char_to_sym(item.in_byte, alphabet_q);

	// Map one item to its beats and the next group state
	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			beat[i] = '0;
		end
		n_beats = '0;
		phase_d = phase_q;
		carry_d = carry_q;
		halted_d = halted_q;
		third_missing_d = third_missing_q;

		if (direction_q == DIR_ENCODE) begin
			case (phase_q)
				2'd1: begin
					beat[0].out_byte = sym_to_char(carry_q | {2'b0, item.in_byte[7:4]},
						alphabet_q);
					beat[0].out_valid = 1'b1;
					n_beats = RES_CNT_W'(1);
					carry_d = {item.in_byte[3:0], 2'b0};
					phase_d = 2'd2;
				end
				2'd2: begin
					beat[0].out_byte = sym_to_char(carry_q | {4'b0, item.in_byte[7:6]},
						alphabet_q);
					beat[0].out_valid = 1'b1;
					beat[1].out_byte = sym_to_char(item.in_byte[5:0], alphabet_q);
					beat[1].out_valid = 1'b1;
					n_beats = RES_CNT_W'(2);
					carry_d = '0;
					phase_d = 2'd0;
				end
				default: begin
					beat[0].out_byte = sym_to_char(item.in_byte[7:2], alphabet_q);
					beat[0].out_valid = 1'b1;
					n_beats = RES_CNT_W'(1);
					carry_d = {item.in_byte[1:0], 4'b0};
					phase_d = 2'd1;
				end
			endcase

			// Flush the partial group and, if padding is enabled, pad it out
			if (item.in_last) begin
				if (phase_d != 2'd0) begin
					beat[n_beats[RES_IDX_W-1:0]].out_byte = sym_to_char(carry_d, alphabet_q);
					beat[n_beats[RES_IDX_W-1:0]].out_valid = 1'b1;
					n_beats = n_beats + RES_CNT_W'(1);
					if (pad_enable_q) begin
						beat[n_beats[RES_IDX_W-1:0]].out_byte = CHAR_PAD;
						beat[n_beats[RES_IDX_W-1:0]].out_valid = 1'b1;
						n_beats = n_beats + RES_CNT_W'(1);
						if (phase_d == 2'd1) begin
							beat[n_beats[RES_IDX_W-1:0]].out_byte = CHAR_PAD;
							beat[n_beats[RES_IDX_W-1:0]].out_valid = 1'b1;
							n_beats = n_beats + RES_CNT_W'(1);
						end
					end
				end
				beat[RES_IDX_W'(n_beats - RES_CNT_W'(1))].out_last = 1'b1;
			end
		end else begin
			if (!halted_q) begin
				case (phase_q)
					2'd0: begin
						if (look.bad) begin
							halted_d = 1'b1;
						end else begin
							carry_d = look.sym;
							phase_d = 2'd1;
						end
					end
					2'd1: begin
						if (look.bad) begin
							halted_d = 1'b1;
						end else begin
							beat[0].out_byte = {carry_q, look.sym[5:4]};
							beat[0].out_valid = 1'b1;
							n_beats = RES_CNT_W'(1);
							carry_d = look.sym;
							phase_d = 2'd2;
						end
					end
					2'd2: begin
						if (look.bad) begin
							third_missing_d = 1'b1;
						end else begin
							beat[0].out_byte = {carry_q[3:0], look.sym[5:2]};
							beat[0].out_valid = 1'b1;
							n_beats = RES_CNT_W'(1);
							carry_d = look.sym;
							third_missing_d = 1'b0;
						end
						phase_d = 2'd3;
					end
					default: begin
						if (!look.bad && !third_missing_q) begin
							beat[0].out_byte = {carry_q[1:0], look.sym};
							beat[0].out_valid = 1'b1;
							n_beats = RES_CNT_W'(1);
						end
						carry_d = '0;
						third_missing_d = 1'b0;
						phase_d = 2'd0;
					end
				endcase
			end

			// Close the message, with a bare end marker if nothing left
			if (item.in_last) begin
				if (n_beats == RES_CNT_W'(0)) begin
					beat[0].decode_error = halted_d;
					n_beats = RES_CNT_W'(1);
				end
				beat[0].out_last = 1'b1;
			end
		end

		// End of message returns the group state to reset
		if (item.in_last) begin
			phase_d = 2'd0;
			carry_d = '0;
			halted_d = 1'b0;
			third_missing_d = 1'b0;
		end
	end

	// Advance group state on accepted items; register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIRECTION_RST;
			alphabet_q <= ALPHABET_RST;
			pad_enable_q <= PAD_ENABLE_RST;
			phase_q <= 2'd0;
			carry_q <= '0;
			halted_q <= 1'b0;
			third_missing_q <= 1'b0;
		end else begin
			if (cfg_acc && cfg.index == CFG_DIRECTION) begin
				phase_q <= 2'd0;
				carry_q <= '0;
				halted_q <= 1'b0;
				third_missing_q <= 1'b0;
			end else if (item_acc) begin
				phase_q <= phase_d;
				carry_q <= carry_d;
				halted_q <= halted_d;
				third_missing_q <= third_missing_d;
			end
			if (cfg_acc) begin
				case (cfg.index)
					CFG_DIRECTION: direction_q <= cfg.data[0];
					CFG_ALPHABET: alphabet_q <= cfg.data[0];
					CFG_PAD_ENABLE: pad_enable_q <= cfg.data[0];
					default: ;
				endcase
			end
		end
	end

	// Count beats held in the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (item_acc) begin
			cnt_q <= n_beats;
		end else if (res_pop) begin
			cnt_q <= cnt_q - RES_CNT_W'(1);
		end
	end

	// Load a fresh list or drop the head beat
	always_ff @(posedge clk) begin
		if (item_acc) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= beat[i];
			end
		end else if (res_pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
			res_q[MAX_RES - 1] <= '0;
		end
	end

endmodule

`default_nettype wire

// ----- src/b64c_checker.sv -----
// Port-level checks of the Base64 stream codec and their binding to the top level.
`default_nettype none

module b64c_checker
	import b64c_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [BYTE_W-1:0] out_byte,
	input wire logic              out_valid,
	input wire logic              out_last,
	input wire logic              decode_error
);

	// Hold a stalled beat
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(out_last))
		else $error("result beat changed while stalled");

	// Take no item while a beat waits that cannot leave
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !res_ready |-> !res_valid)
		else $error("input ready while result buffer stalled");

	// A beat without data is the end of its message
	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_last && out_byte == '0)
		else $error("bare end marker malformed");

	// Errors ride only on bare end markers
	a_err_bare: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && decode_error |-> !out_valid && out_last)
		else $error("decode error on a data beat");

	// Nothing leaves without an item having been taken since reset
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(in_valid && in_ready))
		else $error("result beat without an accepted item");

endmodule

bind base64_stream_codec_top b64c_checker u_b64c_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.out_byte     (result.out_byte),
	.out_valid    (result.out_valid),
	.out_last     (result.out_last),
	.decode_error (result.decode_error)
);

`default_nettype wire
